### sv/quaternion_to_euler_angles_assert.svh
// Assertion macros for the port-level checker
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// Implication checked on every rising clock edge, with reset masked
`define Q2E_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, with reset masked
`define Q2E_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/q2e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package q2e_pkg;

   // Iterations of each vectoring CORDIC
   localparam int CordicSteps = 14;
   localparam int TableLen    = 25;
   localparam int NumIters    = (CordicSteps < TableLen) ? CordicSteps : TableLen;

   // Datapath widths
   localparam int VecW  = 36;   // CORDIC vector, Q.28 with growth headroom
   localparam int AccW  = 34;   // angle accumulator, 2^31 means pi
   localparam int ProdW = 35;   // 2*(a*b + c*d) signed
   localparam int SqrtW = 29;   // isqrt of a 57 bit value
   localparam int SqrtIn = 58;  // radicand width, even

   localparam logic signed [AccW-1:0] HalfTurn    = 34'sd2147483648;
   localparam logic signed [AccW-1:0] QuarterTurn = 34'sd1073741824;
   localparam logic [31:0] PiQ29 = 32'd1686629713;
   localparam logic signed [ProdW-1:0] OneQ28 = 35'sd268435456;

   // atan(2^-k) in binary angle units
   function automatic logic [AccW-1:0] atan_unit(input int k);
      logic [AccW-1:0] t;
      case (k)
         0:  t = 34'd536870912;
         1:  t = 34'd316933406;
         2:  t = 34'd167458907;
         3:  t = 34'd85004756;
         4:  t = 34'd42667331;
         5:  t = 34'd21354465;
         6:  t = 34'd10679838;
         7:  t = 34'd5340245;
         8:  t = 34'd2670163;
         9:  t = 34'd1335087;
         10: t = 34'd667544;
         11: t = 34'd333772;
         12: t = 34'd166886;
         13: t = 34'd83443;
         14: t = 34'd41722;
         15: t = 34'd20861;
         16: t = 34'd10430;
         17: t = 34'd5215;
         18: t = 34'd2608;
         19: t = 34'd1304;
         20: t = 34'd652;
         21: t = 34'd326;
         22: t = 34'd163;
         23: t = 34'd81;
         24: t = 34'd41;
         default: t = '0;
      endcase
      return t;
   endfunction

   // State of one CORDIC lane between stages
   typedef struct packed {
      logic signed [VecW-1:0] vx;
      logic signed [VecW-1:0] vy;
      logic signed [AccW-1:0] acc;
      logic                   zero;
   } lane_type;

endpackage
`default_nettype wire

### sv/q2e_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring square root, one result bit per stage.
// Carries the pitch numerator and saturation flags alongside.
module q2e_isqrt (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire logic [q2e_pkg::SqrtIn-1:0]        in_rad,
   input  wire logic signed [q2e_pkg::ProdW-1:0]  in_arg,
   input  wire logic [1:0]                        in_sat,
   output logic                                   out_valid,
   output logic [q2e_pkg::SqrtW-1:0]              out_root,
   output logic signed [q2e_pkg::ProdW-1:0]       out_arg,
   output logic [1:0]                             out_sat
);
   import q2e_pkg::*;

   localparam int NS = SqrtIn / 2;

   logic [NS:0]                       vld_ff;
   logic [SqrtIn-1:0]                 rem_ff  [NS+1];
   logic [SqrtW-1:0]                  root_ff [NS+1];
   logic [SqrtIn-1:0]                 rad_ff  [NS+1];
   logic signed [ProdW-1:0]           arg_ff  [NS+1];
   logic [1:0]                        sat_ff  [NS+1];

   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else vld_ff[0] <= in_valid;
      rem_ff[0]  <= '0;
      root_ff[0] <= '0;
      rad_ff[0]  <= in_rad;
      arg_ff[0]  <= in_arg;
      sat_ff[0]  <= in_sat;
   end

   // One bit pair of the radicand per stage
   for (genvar i = 0; i < NS; i++) begin : g_st
      logic [SqrtIn-1:0] rem_in;
      logic [SqrtIn-1:0] trial;
      logic [SqrtW-1:0]  root_in;
      always_comb begin
         rem_in = {rem_ff[i][SqrtIn-3:0], rad_ff[i][SqrtIn-1-2*i -: 2]};
         trial  = {{(SqrtIn-SqrtW-2){1'b0}}, root_ff[i], 2'b01};
         if (rem_in >= trial) begin
            rem_in  = rem_in - trial;
            root_in = {root_ff[i][SqrtW-2:0], 1'b1};
         end else begin
            root_in = {root_ff[i][SqrtW-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) vld_ff[i+1] <= 1'b0;
         else vld_ff[i+1] <= vld_ff[i];
         rem_ff[i+1]  <= rem_in;
         root_ff[i+1] <= root_in;
         rad_ff[i+1]  <= rad_ff[i];
         arg_ff[i+1]  <= arg_ff[i];
         sat_ff[i+1]  <= sat_ff[i];
      end
   end

   assign out_valid = vld_ff[NS];
   assign out_root  = root_ff[NS];
   assign out_arg   = arg_ff[NS];
   assign out_sat   = sat_ff[NS];
endmodule
`default_nettype wire

### sv/q2e_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// Vectoring CORDIC atan2, one iteration per stage, clamped to +-pi.
// Output is the angle in Q2.13 radians, rounded half away from zero.
module q2e_cordic (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             in_valid,
   input  wire logic signed [q2e_pkg::VecW-1:0]  in_num,
   input  wire logic signed [q2e_pkg::VecW-1:0]  in_den,
   output logic                                  out_valid,
   output logic signed [15:0]                    out_angle
);
   import q2e_pkg::*;

   localparam int NI = NumIters;

   logic [NI:0]  vld_ff;
   lane_type     ln_ff [NI+1];
   lane_type     pre_in;

   // Pre-rotation into the right half plane
   always_comb begin
      pre_in.zero = (in_num == '0) && (in_den == '0);
      pre_in.vx   = in_den;
      pre_in.vy   = in_num;
      pre_in.acc  = '0;
      if (in_den < 0) begin
         pre_in.acc = (in_num >= 0) ? HalfTurn : -HalfTurn;
         pre_in.vx  = -in_den;
         pre_in.vy  = -in_num;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff[0] <= 1'b0;
      else vld_ff[0] <= in_valid;
      ln_ff[0] <= pre_in;
   end

   for (genvar k = 0; k < NI; k++) begin : g_it
      lane_type nx_in;
      always_comb begin
         nx_in = ln_ff[k];
         if (ln_ff[k].vy > 0) begin
            nx_in.vx  = ln_ff[k].vx + (ln_ff[k].vy >>> k);
            nx_in.vy  = ln_ff[k].vy - (ln_ff[k].vx >>> k);
            nx_in.acc = ln_ff[k].acc + $signed(atan_unit(k));
         end else begin
            nx_in.vx  = ln_ff[k].vx - (ln_ff[k].vy >>> k);
            nx_in.vy  = ln_ff[k].vy + (ln_ff[k].vx >>> k);
            nx_in.acc = ln_ff[k].acc - $signed(atan_unit(k));
         end
      end
      always_ff @(posedge clock) begin
         if (reset) vld_ff[k+1] <= 1'b0;
         else vld_ff[k+1] <= vld_ff[k];
         ln_ff[k+1] <= nx_in;
      end
   end

   // Clamp and magnitude
   logic signed [AccW-1:0] cl;
   logic [31:0]            mag_in, mag_ff;
   logic                   neg_in, neg_ff, v1_ff;
   always_comb begin
      cl = ln_ff[NI].zero ? '0 : ln_ff[NI].acc;
      if (cl > HalfTurn) cl = HalfTurn;
      if (cl < -HalfTurn) cl = -HalfTurn;
      neg_in = cl[AccW-1];
      mag_in = neg_in ? 32'(-cl) : 32'(cl);
   end

   // Scale to radians: one 32x32 multiply, then round
   logic [63:0] prod_ff;
   logic        neg2_ff, v2_ff;
   logic [15:0] r_in, ang_ff;
   logic        v3_ff;
   always_comb begin
      r_in = 16'((prod_ff + (64'd1 << 46)) >> 47);
      if (neg2_ff) r_in = -r_in;
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= vld_ff[NI];
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      prod_ff <= 64'(mag_ff) * 64'(PiQ29);
      neg2_ff <= neg_ff;
      ang_ff  <= r_in;
   end

   assign out_valid = v3_ff;
   assign out_angle = ang_ff;
endmodule
`default_nettype wire

### sv/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   | Ports                                       | Handshake
// request   | req_quat_w/x/y/z                            | start high, busy low
// response  | rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle | rsp_valid one cycle
//
// One item enters every cycle; busy is always low.
// The pitch path has 4 front stages (capture, products, sums, pitch square),
// 30 square-root stages, 1 pre-rotation, 14 CORDIC iterations and 3 scaling
// stages (the square-root pipe sets the pitch path).
// Roll and yaw go through delay lines to meet pitch.
// Synchronous reset clears all valid bits; data registers are not reset.
// No stall exists: the receiver always takes the result.
module quaternion_to_euler_angles (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [15:0] req_quat_w,
   input  wire logic signed [15:0] req_quat_x,
   input  wire logic signed [15:0] req_quat_y,
   input  wire logic signed [15:0] req_quat_z,
   output logic                    rsp_valid,
   output logic signed [15:0]      rsp_roll_angle,
   output logic signed [14:0]      rsp_pitch_angle,
   output logic signed [15:0]      rsp_yaw_angle
);
   import q2e_pkg::*;

   localparam int SqDly = SqrtIn / 2 + 1;

   assign busy = 1'b0;

   // Stage 1: input capture
   logic               v0_ff;
   logic signed [15:0] w_ff, x_ff, y_ff, z_ff;
   // Stage 2: single products
   logic               v1_ff;
   logic signed [31:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;
   // Stage 3: sums
   logic               v2_ff;
   logic signed [ProdW-1:0] rn_ff, rd_ff, pa_ff, yn_ff, yd_ff;
   // Stage 4: pitch square and saturation
   logic               v3_ff;
   logic [SqrtIn-1:0]  rad_ff;
   logic signed [ProdW-1:0] pa3_ff;
   logic [1:0]         sat_ff;
   logic [63:0]        sq_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= start;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      w_ff <= req_quat_w;
      x_ff <= req_quat_x;
      y_ff <= req_quat_y;
      z_ff <= req_quat_z;
      wx_ff <= w_ff * x_ff;
      yz_ff <= y_ff * z_ff;
      xx_ff <= x_ff * x_ff;
      yy_ff <= y_ff * y_ff;
      wy_ff <= w_ff * y_ff;
      zx_ff <= z_ff * x_ff;
      wz_ff <= w_ff * z_ff;
      xy_ff <= x_ff * y_ff;
      zz_ff <= z_ff * z_ff;
      rn_ff <= 35'(wx_ff) + 35'(yz_ff) <<< 1;
      rd_ff <= OneQ28 - ((35'(xx_ff) + 35'(yy_ff)) <<< 1);
      pa_ff <= (35'(wy_ff) - 35'(zx_ff)) <<< 1;
      yn_ff <= (35'(wz_ff) + 35'(xy_ff)) <<< 1;
      yd_ff <= OneQ28 - ((35'(yy_ff) + 35'(zz_ff)) <<< 1);
      pa3_ff <= pa_ff;
      sat_ff <= {pa_ff >= OneQ28, pa_ff <= -OneQ28};
      rad_ff <= SqrtIn'((64'd1 << 56) - sq_in);
   end

   // Square of pitch argument; only used when |arg| < 1, so it fits 56 bits
   assign sq_in = 64'($signed(pa_ff) * $signed(pa_ff));

   // Pitch: square root then CORDIC
   logic                    sv_w;
   logic [SqrtW-1:0]        root_w;
   logic signed [ProdW-1:0] parg_w;
   logic [1:0]              psat_w;

   q2e_isqrt u_sqrt (
      .clock, .reset,
      .in_valid (v3_ff), .in_rad (rad_ff), .in_arg (pa3_ff), .in_sat (sat_ff),
      .out_valid (sv_w), .out_root (root_w), .out_arg (parg_w), .out_sat (psat_w)
   );

   // Saturation flags ride a delay line matched to the CORDIC
   localparam int CDly = NumIters + 4;
   logic [1:0] psd_ff [CDly];
   always_ff @(posedge clock) begin
      psd_ff[0] <= psat_w;
      for (int i = 1; i < CDly; i++) psd_ff[i] <= psd_ff[i-1];
   end

   logic               pv_w;
   logic signed [15:0] pang_w;
   q2e_cordic u_pitch (
      .clock, .reset, .in_valid (sv_w),
      .in_num (VecW'(parg_w)), .in_den ($signed(VecW'(root_w))),
      .out_valid (pv_w), .out_angle (pang_w)
   );

   // Roll/yaw operands delayed to line up with pitch
   logic signed [ProdW-1:0] dl_ff [SqDly+1][4];
   logic [SqDly:0]          dv_ff;
   always_ff @(posedge clock) begin
      if (reset) dv_ff <= '0;
      else dv_ff <= {dv_ff[SqDly-1:0], v2_ff};
      dl_ff[0][0] <= rn_ff;
      dl_ff[0][1] <= rd_ff;
      dl_ff[0][2] <= yn_ff;
      dl_ff[0][3] <= yd_ff;
      for (int i = 1; i <= SqDly; i++) dl_ff[i] <= dl_ff[i-1];
   end

   logic rv_w, yv_w;
   logic signed [15:0] rang_w, yang_w;
   q2e_cordic u_roll (
      .clock, .reset, .in_valid (dv_ff[SqDly]),
      .in_num (VecW'(dl_ff[SqDly][0])), .in_den (VecW'(dl_ff[SqDly][1])),
      .out_valid (rv_w), .out_angle (rang_w)
   );
   q2e_cordic u_yaw (
      .clock, .reset, .in_valid (dv_ff[SqDly]),
      .in_num (VecW'(dl_ff[SqDly][2])), .in_den (VecW'(dl_ff[SqDly][3])),
      .out_valid (yv_w), .out_angle (yang_w)
   );

   // Output select with pitch saturation
   logic [1:0] ps_w;
   assign ps_w = psd_ff[CDly-1];
   assign rsp_valid      = pv_w;
   assign rsp_roll_angle = rang_w;
   assign rsp_yaw_angle  = yang_w;
   always_comb begin
      if (ps_w[1])      rsp_pitch_angle = 15'sd12868;
      else if (ps_w[0]) rsp_pitch_angle = -15'sd12868;
      else              rsp_pitch_angle = 15'(pang_w);
   end

   logic unused_ok;
   assign unused_ok = rv_w ^ yv_w;
endmodule
`default_nettype wire

### sv/q2e_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_to_euler_angles_assert.svh"
// Port-level checks on the converter
module q2e_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic               rsp_valid,
   input wire logic signed [15:0] rsp_roll_angle,
   input wire logic signed [14:0] rsp_pitch_angle,
   input wire logic signed [15:0] rsp_yaw_angle
);
   `Q2E_ASSERT_IMPL(a_never_busy, clock, reset, 1'b1, !busy, "busy raised")
   `Q2E_ASSERT_IMPL(a_roll_rng, clock, reset, rsp_valid,
      rsp_roll_angle <= 16'sd25736 && rsp_roll_angle >= -16'sd25736, "roll range")
   `Q2E_ASSERT_IMPL(a_yaw_rng, clock, reset, rsp_valid,
      rsp_yaw_angle <= 16'sd25736 && rsp_yaw_angle >= -16'sd25736, "yaw range")
   `Q2E_ASSERT_NEXT(a_pitch_rng, clock, reset, rsp_valid,
      $past(rsp_pitch_angle) <= 15'sd12868 && $past(rsp_pitch_angle) >= -15'sd12868,
      "pitch range")
endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (.*);
`default_nettype wire

### test/euler_checker.sv
`timescale 1ns / 1ps
module euler_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic               rsp_valid,
   input  logic signed [15:0] rsp_roll_angle,
   input  logic signed [14:0] rsp_pitch_angle,
   input  logic signed [15:0] rsp_yaw_angle,
   output int                 fail_count,
   output int                 pending_count,
   output int                 angles_seen
);
   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [14:0] pitch;
      logic signed [15:0] yaw;
   } angle_set_type;

   angle_set_type expected_angles[$];
   longint     atan_tbl[25] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41};

   // vectoring atan2 in binary angle units, 2^31 = pi
   function automatic longint vector_angle(input longint num, input longint den);
      longint vx, vy, acc, dx, dy;
      vx = den; vy = num; acc = 0;
      if (num == 0 && den == 0) return 0;
      if (vx < 0) begin
         acc = (vy >= 0) ? 64'sd2147483648 : -64'sd2147483648;
         vx = -vx;
         vy = -vy;
      end
      for (int k = 0; k < q2e_pkg::NumIters; k++) begin
         dx = vy >>> k;
         dy = vx >>> k;
         if (vy > 0) begin
            vx += dx; vy -= dy; acc += atan_tbl[k];
         end else begin
            vx -= dx; vy += dy; acc -= atan_tbl[k];
         end
      end
      if (acc > 64'sd2147483648) acc = 64'sd2147483648;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      return acc;
   endfunction

   function automatic longint root_floor(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   // binary angle to Q2.13 radians, halves away from zero
   function automatic longint to_radians(input longint a);
      longint unsigned m;
      longint r;
      m = (a < 0 ? -a : a);
      m = m * 64'd1686629713;
      r = (m + (64'd1 << 46)) >> 47;
      return a < 0 ? -r : r;
   endfunction

   function automatic angle_set_type predict_angles(input longint w, x, y, z);
      angle_set_type s;
      longint one, rn, rd, pa, yn, yd, pang;
      one = 64'sd1 << 28;
      rn = 2 * (w * x + y * z);
      rd = one - 2 * (x * x + y * y);
      pa = 2 * (w * y - z * x);
      yn = 2 * (w * z + x * y);
      yd = one - 2 * (y * y + z * z);
      if (pa >= one) pang = 64'sd1073741824;
      else if (pa <= -one) pang = -64'sd1073741824;
      else pang = vector_angle(pa, root_floor((64'd1 << 56) - pa * pa));
      s.roll = 16'(to_radians(vector_angle(rn, rd)));
      s.pitch = 15'(to_radians(pang));
      s.yaw = 16'(to_radians(vector_angle(yn, yd)));
      return s;
   endfunction

   // record on accept, compare on strobe
   always @(posedge clock) begin
      angle_set_type e;
      if (reset) begin
         fail_count <= 0;
         angles_seen <= 0;
      end else begin
         if (start && !busy)
            expected_angles.push_back(predict_angles(req_quat_w, req_quat_x,
               req_quat_y, req_quat_z));
         if (rsp_valid) begin
            angles_seen <= angles_seen + 1;
            if (expected_angles.size() == 0) begin
               $display("%0t: unexpected result r=%0d p=%0d y=%0d", $time,
                  rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_angles.pop_front();
               if (e.roll !== rsp_roll_angle || e.pitch !== rsp_pitch_angle ||
                   e.yaw !== rsp_yaw_angle) begin
                  $display("%0t: expected r=%0d p=%0d y=%0d got r=%0d p=%0d y=%0d",
                     $time, e.roll, e.pitch, e.yaw, rsp_roll_angle,
                     rsp_pitch_angle, rsp_yaw_angle);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_count <= expected_angles.size();
   end
endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic signed [15:0] req_quat_w = 0, req_quat_x = 0, req_quat_y = 0, req_quat_z = 0;
   logic               rsp_valid;
   logic signed [15:0] rsp_roll_angle, rsp_yaw_angle;
   logic signed [14:0] rsp_pitch_angle;
   int                 fail_count, pending_count, angles_seen;
   int                 sent;

   always #2 clock = ~clock;

   quaternion_to_euler_angles dut (.*);
   euler_checker checker_i (.*);

   function automatic logic signed [15:0] pick_component(input int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'($urandom_range(32768) - 16384);
         default: return 16'($urandom_range(4000) - 2000);
      endcase
   endfunction

   task automatic send_quat(input logic signed [15:0] w, x, y, z);
      start <= 1;
      req_quat_w <= w; req_quat_x <= x; req_quat_y <= y; req_quat_z <= z;
      do @(posedge clock); while (busy);
      sent++;
   endtask

   initial begin
      logic signed [15:0] d[10] = '{0, 1, -1, 16384, -16384, 11585, -11585,
         16'h7fff, 16'h8000, 8192};
      int m;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: identity, axis turns, gimbal lock, zero and extreme patterns
      send_quat(16384, 0, 0, 0);
      send_quat(0, 0, 0, 0);
      send_quat(0, 16384, 0, 0);
      send_quat(0, 0, 16384, 0);
      send_quat(0, 0, 0, 16384);
      send_quat(-16384, 0, 0, 0);
      send_quat(11585, 0, 11585, 0);
      send_quat(11585, 0, -11585, 0);
      send_quat(11585, 11585, 0, 0);
      send_quat(0, -16384, -1, 0);
      send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
      send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
      send_quat(-1, -1, -1, -1);
      send_quat(8192, 8192, 8192, -8192);
      for (int i = 0; i < 8; i++)
         send_quat(d[$urandom_range(9)], d[$urandom_range(9)], d[$urandom_range(9)],
            d[$urandom_range(9)]);
      // random: idle cycles between items, except over a back-to-back stretch
      for (int i = 0; i < 650; i++) begin
         while ((i < 200 || i > 350) && $urandom_range(99) < 31) begin
            start <= 0;
            @(posedge clock);
         end
         m = $urandom_range(9) < 2 ? 0 : ($urandom_range(3) == 0 ? 2 : 1);
         send_quat(pick_component(m), pick_component(m), pick_component(m),
            pick_component(m));
      end
      start <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("%0d quaternions sent, %0d angle sets checked", sent, angles_seen);
      if (fail_count == 0 && pending_count == 0) $display("tb_top OK");
      else $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      #200000;
      $display("tb_top NOT OK");
      $finish;
   end
endmodule
